// File: sv/hsv565_pkg.sv
package hsv565_pkg;

  localparam logic [7:0]  HUE_SECTOR = 8'd43;
  localparam logic [7:0]  FRAC_SCALE = 8'd6;
  localparam logic [7:0]  CHAN_MAX   = 8'd255;
  localparam logic [15:0] MAX5       = 16'd31;
  localparam logic [15:0] MAX6       = 16'd63;

  localparam logic [2:0] SECTOR_0 = 3'd0;
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;
  localparam logic [2:0] SECTOR_5 = 3'd5;

  typedef struct packed {
    logic       valid;
    logic       grey;
    logic [2:0] region;
    logic [7:0] v;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
  } front_t;

  // exact floor(x / 255) for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return sum[15:8];
  endfunction

endpackage

// File: sv/hsv565_front.sv
module hsv565_front import hsv565_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  logic [7:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  output front_t     res
);

  // stage 1: sector and fraction
  logic       s1_valid;
  logic       s1_grey;
  logic [2:0] s1_region;
  logic [7:0] s1_frac;
  logic [7:0] s1_s;
  logic [7:0] s1_v;

  logic [2:0] region_next;
  logic [7:0] rem;
  logic [7:0] frac_next;

  always_comb begin
    if (hue >= 8'd215) begin
      region_next = SECTOR_5;
    end else if (hue >= 8'd172) begin
      region_next = SECTOR_4;
    end else if (hue >= 8'd129) begin
      region_next = SECTOR_3;
    end else if (hue >= 8'd86) begin
      region_next = SECTOR_2;
    end else if (hue >= HUE_SECTOR) begin
      region_next = SECTOR_1;
    end else begin
      region_next = SECTOR_0;
    end
    rem       = hue - 8'({5'd0, region_next} * HUE_SECTOR);
    frac_next = 8'(rem * FRAC_SCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_grey   <= (saturation == 8'd0);
      s1_region <= region_next;
      s1_frac   <= frac_next;
      s1_s      <= saturation;
      s1_v      <= brightness;
    end
  end

  // stage 2: saturation products and p
  logic       s2_valid;
  logic       s2_grey;
  logic [2:0] s2_region;
  logic [7:0] s2_v;
  logic [7:0] s2_p;
  logic [7:0] s2_qk;
  logic [7:0] s2_tk;

  logic [15:0] sf;
  logic [15:0] sfc;
  logic [15:0] pv;

  always_comb begin
    sf  = {8'd0, s1_s} * {8'd0, s1_frac};
    sfc = {8'd0, s1_s} * {8'd0, CHAN_MAX - s1_frac};
    pv  = {8'd0, s1_v} * {8'd0, CHAN_MAX - s1_s};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_grey   <= s1_grey;
      s2_region <= s1_region;
      s2_v      <= s1_v;
      s2_p      <= pv[15:8];
      s2_qk     <= CHAN_MAX - sf[15:8];
      s2_tk     <= CHAN_MAX - sfc[15:8];
    end
  end

  // stage 3: q and t
  logic [15:0] qv;
  logic [15:0] tv;

  always_comb begin
    qv = {8'd0, s2_v} * {8'd0, s2_qk};
    tv = {8'd0, s2_v} * {8'd0, s2_tk};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= s2_valid;
    end
    if (en) begin
      res.grey   <= s2_grey;
      res.region <= s2_region;
      res.v      <= s2_v;
      res.p      <= s2_p;
      res.q      <= qv[15:8];
      res.t      <= tv[15:8];
    end
  end

endmodule

// File: sv/hsv_to_rgb565_swapped_unit.sv
// throughput: one item per cycle while the output is not stalled; four register stages (sector, saturation
// products, q/t products, channel reduction and pack)
// the whole pipeline holds while the output item is stalled
// synchronous active-high reset clears all valid bits; data registers are not reset
module hsv_to_rgb565_swapped_unit import hsv565_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pixel_word
);

  logic   en;
  front_t front;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  hsv565_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .res        (front)
  );

  logic [7:0]  r;
  logic [7:0]  g;
  logic [7:0]  b;
  logic [7:0]  r5;
  logic [7:0]  g6;
  logic [7:0]  b5;
  logic [15:0] word;

  always_comb begin
    if (front.grey) begin
      r = front.v;
      g = front.v;
      b = front.v;
    end else begin
      case (front.region)
        SECTOR_0: begin
          r = front.v; g = front.t; b = front.p;
        end
        SECTOR_1: begin
          r = front.q; g = front.v; b = front.p;
        end
        SECTOR_2: begin
          r = front.p; g = front.v; b = front.t;
        end
        SECTOR_3: begin
          r = front.p; g = front.q; b = front.v;
        end
        SECTOR_4: begin
          r = front.t; g = front.p; b = front.v;
        end
        default: begin
          r = front.v; g = front.p; b = front.q;
        end
      endcase
    end
    r5   = div255({8'd0, r} * MAX5);
    g6   = div255({8'd0, g} * MAX6);
    b5   = div255({8'd0, b} * MAX5);
    word = {r5[4:0], g6[5:0], b5[4:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= front.valid;
    end
    if (en) begin
      pixel_word <= {word[7:0], word[15:8]};
    end
  end

endmodule

// File: sv/hsv565_checker.sv
module hsv565_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  saturation,
  input logic [7:0]  brightness,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] pixel_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_word))
    else $error("stalled output item changed");

  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting output item");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // black in gives a zero pixel on the output when nothing stalls on the way
  a_black: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && brightness == 8'd0) ##1 !in_stall ##1 !in_stall
    ##1 !in_stall
    |=> out_valid && pixel_word == 16'h0000)
    else $error("black item gave a wrong pixel");

  // full white grey gives all ones
  a_white: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && saturation == 8'd0 && brightness == 8'hff)
    ##1 !in_stall ##1 !in_stall ##1 !in_stall
    |=> out_valid && pixel_word == 16'hffff)
    else $error("white item gave a wrong pixel");

endmodule

bind hsv_to_rgb565_swapped_unit hsv565_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .saturation (saturation),
  .brightness (brightness),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .pixel_word (pixel_word)
);
